/* hdl/ehs_pkg.sv */
// Package for the explicit 1D heat stencil block.
// Holds the configuration, command and status types, codes and constants.
// No dependencies.
`default_nettype none

package ehs_pkg;

  // Default storage depth of the temperature field
  localparam int MAX_NODES_DEF = 128;

  // APB address width: six 32-bit registers at byte address 4*i
  localparam int APB_AW = 5;

  // Q1.16 one, for the decay factor
  localparam logic [16:0] DECAY_ONE = 17'd65536;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_STEP    = 2'd0,
    KIND_READ    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  // Register indexes (paddr[4:2])
  typedef enum logic [2:0] {
    REG_LAST_NODE    = 3'd0,
    REG_DIFF_RATIO   = 3'd1,
    REG_SRC_INCR     = 3'd2,
    REG_SRC_FIRST    = 3'd3,
    REG_SRC_LAST     = 3'd4,
    REG_DECAY_FACTOR = 3'd5
  } reg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_CLEAR,
    ST_RESP
  } ctrl_state_e;

  typedef struct packed {
    logic [6:0]  last_node;
    logic [15:0] diffusion_ratio;
    logic [30:0] source_increment;
    logic [6:0]  source_first;
    logic [6:0]  source_last;
    logic [16:0] decay_per_step;
  } cfg_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_we;      // write zero at the address bus (clearing pass)
    logic step_start;  // latch source term, clear the stencil window
    logic issue;       // push one stencil slot into the pipeline
    logic issue_zero;  // slot past the last node: feed zero instead of memory data
    logic rd_en;       // read one node for a read transaction
    logic restart;     // reset peak and decay
    logic decay_upd;   // advance decay at the end of a step
    logic out_load;    // load the result register
    logic out_rd;      // result carries the read node value
  } cmd_t;

  typedef struct packed {
    logic busy;        // stencil pipeline still holds nodes
  } sts_t;

endpackage

`default_nettype wire

/* hdl/ehs_if.sv */
// Handshake interfaces for item and result transactions.
// Depends on nothing; used by the top level.
`default_nettype none

interface ehs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [6:0] node_index;

  modport source (output valid, output kind, output node_index, input ready);
  modport sink   (input valid, input kind, input node_index, output ready);
endinterface

interface ehs_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] node_value;
  logic        [30:0] peak_value;

  modport source (output valid, output node_value, output peak_value, input ready);
  modport sink   (input valid, input node_value, input peak_value, output ready);
endinterface

`default_nettype wire

/* hdl/ehs_regs.sv */
// APB configuration registers of the heat stencil block.
// Depends on ehs_pkg (cfg_t, reg_idx_e, APB_AW).
`default_nettype none

module ehs_regs (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [ehs_pkg::APB_AW-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output ehs_pkg::cfg_t              cfg_o
);

  ehs_pkg::cfg_t     cfg_q;
  ehs_pkg::reg_idx_e idx;
  logic              wr_en;

  assign idx    = ehs_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Write registers on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.last_node        <= 7'd100;
      cfg_q.diffusion_ratio  <= 16'd16384;
      cfg_q.source_increment <= 31'd4194304;
      cfg_q.source_first     <= 7'd45;
      cfg_q.source_last      <= 7'd55;
      cfg_q.decay_per_step   <= ehs_pkg::DECAY_ONE;
    end else if (wr_en) begin
      case (idx)
        ehs_pkg::REG_LAST_NODE:    cfg_q.last_node        <= pwdata[6:0];
        ehs_pkg::REG_DIFF_RATIO:   cfg_q.diffusion_ratio  <= pwdata[15:0];
        ehs_pkg::REG_SRC_INCR:     cfg_q.source_increment <= pwdata[30:0];
        ehs_pkg::REG_SRC_FIRST:    cfg_q.source_first     <= pwdata[6:0];
        ehs_pkg::REG_SRC_LAST:     cfg_q.source_last      <= pwdata[6:0];
        ehs_pkg::REG_DECAY_FACTOR: cfg_q.decay_per_step   <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      ehs_pkg::REG_LAST_NODE:    prdata = 32'(cfg_q.last_node);
      ehs_pkg::REG_DIFF_RATIO:   prdata = 32'(cfg_q.diffusion_ratio);
      ehs_pkg::REG_SRC_INCR:     prdata = 32'(cfg_q.source_increment);
      ehs_pkg::REG_SRC_FIRST:    prdata = 32'(cfg_q.source_first);
      ehs_pkg::REG_SRC_LAST:     prdata = 32'(cfg_q.source_last);
      ehs_pkg::REG_DECAY_FACTOR: prdata = 32'(cfg_q.decay_per_step);
      default:                   prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/ehs_dp.sv */
// Datapath of the heat stencil: field memory, stencil pipeline, peak and decay.
// Depends on ehs_pkg (cfg_t, cmd_t, sts_t, DECAY_ONE); driven by ehs_ctrl.
`default_nettype none

module ehs_dp #(
  parameter int MAX_NODES = ehs_pkg::MAX_NODES_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  ehs_pkg::cfg_t              cfg_i,
  input  ehs_pkg::cmd_t              cmd_i,
  input  wire  [$clog2(MAX_NODES):0] addr_i,
  output ehs_pkg::sts_t              sts_o,
  output logic signed [31:0]         node_value_o,
  output logic [30:0]                peak_value_o
);

  localparam int AW    = $clog2(MAX_NODES);
  localparam int SW    = AW + 1;
  localparam int CW    = (AW > 7) ? AW : 7;
  localparam int ACC_W = 52;

  // Field storage, one write and one read port
  logic signed [31:0] mem [MAX_NODES];
  logic signed [31:0] rdata_q;
  logic               rd_en;
  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;

  // Stencil window and pipeline
  logic signed [31:0] w_l_q, w_u_q, w_r_q;
  logic               s0_vld_q, s0_zero_q;
  logic [SW-1:0]      s0_slot_q;
  logic               s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;
  logic [AW-1:0]      s1_node_q, s2_node_q, s3_node_q, s4_node_q;
  logic               s2_src_q;
  logic signed [49:0] cu_q;
  logic signed [32:0] lr_q;
  logic signed [49:0] sl_q;
  logic signed [ACC_W-1:0] cu_src_q;
  logic signed [31:0] res_q;
  logic [47:0]        src_q;

  logic signed [17:0] coef_c;
  logic signed [ACC_W-1:0] acc;
  logic signed [31:0] sat_val;
  logic               in_src;
  logic [16:0]        factor;

  // State
  logic [30:0]        peak_q;
  logic [16:0]        decay_q;

  // Coefficient 1 - 2s in Q.16
  assign coef_c = 18'sd65536 - $signed({1'b0, cfg_i.diffusion_ratio, 1'b0});
  assign factor = (cfg_i.decay_per_step > ehs_pkg::DECAY_ONE) ? ehs_pkg::DECAY_ONE
                                                              : cfg_i.decay_per_step;
  assign in_src = (CW'(s1_node_q) >= CW'(cfg_i.source_first)) &&
                  (CW'(s1_node_q) <= CW'(cfg_i.source_last));

  // Memory write: clearing pass or stencil results
  assign we    = cmd_i.clr_we || s4_vld_q;
  assign waddr = cmd_i.clr_we ? addr_i[AW-1:0] : s4_node_q;
  assign wdata = cmd_i.clr_we ? 32'sd0 : res_q;
  assign rd_en = cmd_i.rd_en || (cmd_i.issue && !cmd_i.issue_zero);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem[addr_i[AW-1:0]];
    end
  end

  // Pipeline valids and node indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= cmd_i.issue;
      s1_vld_q <= s0_vld_q && (s0_slot_q != '0);
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  // Shift the window, run the multiply and add stages
  always_ff @(posedge clk_i) begin
    s0_zero_q <= cmd_i.issue_zero;
    s0_slot_q <= addr_i;
    if (cmd_i.step_start) begin
      w_u_q <= '0;
      w_r_q <= '0;
      src_q <= 48'(cfg_i.source_increment) * 48'(decay_q);
    end else if (s0_vld_q) begin
      w_l_q <= w_u_q;
      w_u_q <= w_r_q;
      w_r_q <= s0_zero_q ? 32'sd0 : rdata_q;
    end
    s1_node_q <= AW'(s0_slot_q - SW'(1));
    // Stage M1: c*u and the neighbor sum
    cu_q      <= coef_c * w_u_q;
    lr_q      <= 33'(w_l_q) + 33'(w_r_q);
    s2_node_q <= s1_node_q;
    s2_src_q  <= in_src;
    // Stage M2: s*(l+r) and source term
    sl_q      <= $signed({1'b0, cfg_i.diffusion_ratio}) * lr_q;
    cu_src_q  <= ACC_W'(cu_q) + (s2_src_q ? ACC_W'($signed({1'b0, src_q})) : '0);
    s3_node_q <= s2_node_q;
    // Stage F: floor shift and saturation
    res_q     <= sat_val;
    s4_node_q <= s3_node_q;
  end

  // Drop 16 bits toward minus infinity, saturate to 32 bits
  always_comb begin
    acc = cu_src_q + ACC_W'(sl_q);
    if ((acc[ACC_W-1:47] == '0) || (acc[ACC_W-1:47] == '1)) begin
      sat_val = acc[47:16];
    end else if (acc[ACC_W-1]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7FFF_FFFF;
    end
  end

  // Peak and decay state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      decay_q <= ehs_pkg::DECAY_ONE;
    end else if (cmd_i.restart) begin
      peak_q  <= '0;
      decay_q <= ehs_pkg::DECAY_ONE;
    end else begin
      if (s4_vld_q && !res_q[31] && (res_q[30:0] > peak_q)) begin
        peak_q <= res_q[30:0];
      end
      if (cmd_i.decay_upd) begin
        decay_q <= 17'((34'(decay_q) * 34'(factor)) >> 16);
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      node_value_o <= cmd_i.out_rd ? rdata_q : 32'sd0;
      peak_value_o <= peak_q;
    end
  end

  assign sts_o.busy = s0_vld_q || s1_vld_q || s2_vld_q || s3_vld_q || s4_vld_q;

endmodule

`default_nettype wire

/* hdl/ehs_ctrl.sv */
// Controller of the heat stencil: sequences clearing, stencil sweeps, reads
// and result hand-off. Depends on ehs_pkg (ctrl_state_e, kind_e, cmd_t, sts_t).
`default_nettype none

module ehs_ctrl #(
  parameter int MAX_NODES = ehs_pkg::MAX_NODES_DEF
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         item_valid_i,
  output logic                        item_ready_o,
  input  wire  [1:0]                  item_kind_i,
  input  wire  [6:0]                  item_index_i,
  output logic                        out_valid_o,
  input  wire                         out_ready_i,
  input  wire  [6:0]                  last_node_i,
  input  ehs_pkg::sts_t               sts_i,
  output ehs_pkg::cmd_t               cmd_o,
  output logic [$clog2(MAX_NODES):0]  addr_o
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int SW = AW + 1;
  localparam int unsigned LastMax = MAX_NODES - 1;

  ehs_pkg::ctrl_state_e state_q, state_d;
  ehs_pkg::kind_e       kind_q, kind_in;
  logic [SW-1:0]        slot_q, slot_d;
  logic                 rd_ok_q, rd_ok;
  logic                 out_valid_q;
  logic                 accept, out_free, clr_end, run_end;
  logic [AW-1:0]        last_eff;
  logic [SW-1:0]        last_plus;

  assign kind_in   = ehs_pkg::kind_e'(item_kind_i);
  assign accept    = item_valid_i && item_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;
  assign rd_ok     = 32'(item_index_i) < 32'(MAX_NODES);
  assign last_eff  = (32'(last_node_i) > LastMax) ? AW'(LastMax) : AW'(last_node_i);
  assign last_plus = SW'(last_eff) + SW'(1);
  assign clr_end   = slot_q == SW'(LastMax);
  assign run_end   = slot_q == last_plus;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ehs_pkg::ST_INIT;
      slot_q      <= '0;
      kind_q      <= ehs_pkg::KIND_NONE;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      slot_q  <= slot_d;
      if (accept) begin
        kind_q  <= kind_in;
        rd_ok_q <= rd_ok;
      end
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ehs_pkg::ST_INIT: begin
        if (clr_end) state_d = ehs_pkg::ST_IDLE;
      end
      ehs_pkg::ST_CLEAR: begin
        if (clr_end) state_d = ehs_pkg::ST_RESP;
      end
      ehs_pkg::ST_IDLE: begin
        if (accept) begin
          case (kind_in)
            ehs_pkg::KIND_STEP:    state_d = ehs_pkg::ST_RUN;
            ehs_pkg::KIND_RESTART: state_d = ehs_pkg::ST_CLEAR;
            default:               state_d = ehs_pkg::ST_RESP;
          endcase
        end
      end
      ehs_pkg::ST_RUN: begin
        if (run_end) state_d = ehs_pkg::ST_DRAIN;
      end
      ehs_pkg::ST_DRAIN: begin
        if (!sts_i.busy) state_d = ehs_pkg::ST_RESP;
      end
      ehs_pkg::ST_RESP: begin
        if (out_free) state_d = ehs_pkg::ST_IDLE;
      end
      default: state_d = ehs_pkg::ST_IDLE;
    endcase
  end

  // Outputs and slot counter
  always_comb begin
    cmd_o        = '0;
    addr_o       = slot_q;
    item_ready_o = 1'b0;
    slot_d       = '0;
    case (state_q)
      ehs_pkg::ST_INIT, ehs_pkg::ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        slot_d       = slot_q + SW'(1);
      end
      ehs_pkg::ST_IDLE: begin
        item_ready_o = 1'b1;
        if (accept) begin
          case (kind_in)
            ehs_pkg::KIND_STEP:    cmd_o.step_start = 1'b1;
            ehs_pkg::KIND_RESTART: cmd_o.restart    = 1'b1;
            ehs_pkg::KIND_READ: begin
              cmd_o.rd_en = rd_ok;
              addr_o      = SW'(item_index_i);
            end
            default: ;
          endcase
        end
      end
      ehs_pkg::ST_RUN: begin
        cmd_o.issue      = 1'b1;
        cmd_o.issue_zero = run_end;
        slot_d           = slot_q + SW'(1);
      end
      ehs_pkg::ST_DRAIN: begin
        cmd_o.decay_upd = !sts_i.busy;
      end
      ehs_pkg::ST_RESP: begin
        cmd_o.out_load = out_free;
        cmd_o.out_rd   = (kind_q == ehs_pkg::KIND_READ) && rd_ok_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* hdl/explicit_heat_stencil_1d.sv */
// Explicit 1D heat stencil, Q8.24 field with decaying source and running peak.
// Step: nodes stream one a cycle through a single stencil pipeline over the field
// memory's one read port; the result follows once the pipeline has drained.
// Read and unused kind go straight to the result; restart runs a clearing pass first.
// After reset a clearing pass over all MAX_NODES nodes runs before the first item is
// accepted; configuration writes are taken throughout. One item in flight.
// Depends on ehs_pkg, ehs_if, ehs_regs, ehs_dp, ehs_ctrl.
`default_nettype none

module explicit_heat_stencil_1d #(
  parameter int MAX_NODES = ehs_pkg::MAX_NODES_DEF
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        psel,
  input  wire                        penable,
  input  wire                        pwrite,
  input  wire  [ehs_pkg::APB_AW-1:0] paddr,
  input  wire  [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  ehs_item_if.sink                   item_i,
  ehs_result_if.source               result_o
);

  localparam int AW = $clog2(MAX_NODES);

  ehs_pkg::cfg_t      cfg;
  ehs_pkg::cmd_t      cmd;
  ehs_pkg::sts_t      sts;
  logic [AW:0]        addr;
  logic               out_valid;
  logic               item_ready;
  logic signed [31:0] node_value;
  logic [30:0]        peak_value;

  ehs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ehs_ctrl #(
    .MAX_NODES (MAX_NODES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready),
    .item_kind_i  (item_i.kind),
    .item_index_i (item_i.node_index),
    .out_valid_o  (out_valid),
    .out_ready_i  (result_o.ready),
    .last_node_i  (cfg.last_node),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .addr_o       (addr)
  );

  ehs_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .cmd_i        (cmd),
    .addr_i       (addr),
    .sts_o        (sts),
    .node_value_o (node_value),
    .peak_value_o (peak_value)
  );

  assign item_i.ready        = item_ready;
  assign result_o.valid      = out_valid;
  assign result_o.node_value = node_value;
  assign result_o.peak_value = peak_value;

endmodule

`default_nettype wire

/* tb/sv/explicit_heat_stencil_1d_tb.sv */
// Testbench for explicit_heat_stencil_1d: drives step, read and restart items,
// predicts every result from its own copy of the field, and compares field by field.
// Depends on ehs_pkg, ehs_if and the block's RTL.
module explicit_heat_stencil_1d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ehs_pkg::*;

  localparam int NODE_DEPTH     = MAX_NODES_DEF;
  localparam int MAX_IDLE       = 12;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int DRAIN_CYCLES   = NODE_DEPTH + 24;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint Q24_MAX    = 64'sd2147483647;
  localparam longint Q24_MIN    = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic        [30:0] peak_value;
  } node_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  ehs_item_if   item_bus ();
  ehs_result_if result_bus ();

  // Field model state and its copy of the registers
  logic signed [31:0]  field_model [NODE_DEPTH];
  logic        [30:0]  peak_model;
  logic        [16:0]  decay_model;
  cfg_t                model_cfg;

  node_result_t        node_results_due [$];
  int                  fail_count = 0;
  int                  quiet_cycles = 0;
  bit                  idle_on = 1'b1;

  explicit_heat_stencil_1d i_dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .item_i   (item_bus),
    .result_o (result_bus)
  );

  always #1 clk = ~clk;

  function automatic void clear_field_model();
    foreach (field_model[i]) field_model[i] = '0;
    peak_model  = '0;
    decay_model = DECAY_ONE;
  endfunction

  // Advance the field model by one item and return the result it produces
  function automatic node_result_t apply_to_field_model(kind_e kind, logic [6:0] idx);
    node_result_t       res;
    logic signed [31:0] next_field [NODE_DEPTH];
    longint             s_l, c_l, src_l, u_l, l_l, r_l, acc;
    int                 last;
    logic [16:0]        factor;
    logic [33:0]        decay_prod;
    res.node_value = '0;
    case (kind)
      KIND_STEP: begin
        last  = (model_cfg.last_node > NODE_DEPTH - 1) ? NODE_DEPTH - 1 : model_cfg.last_node;
        s_l   = longint'(model_cfg.diffusion_ratio);
        c_l   = 65536 - 2 * s_l;
        src_l = longint'(model_cfg.source_increment) * longint'(decay_model);
        // sweep from the old field, outside neighbours read as zero
        for (int i = 0; i <= last; i++) begin
          u_l = longint'(field_model[i]);
          l_l = (i > 0) ? longint'(field_model[i-1]) : 0;
          r_l = (i < last) ? longint'(field_model[i+1]) : 0;
          acc = c_l * u_l + s_l * (l_l + r_l);
          if (i >= model_cfg.source_first && i <= model_cfg.source_last) acc += src_l;
          acc = acc >>> 16;
          if (acc > Q24_MAX)      next_field[i] = 32'h7fff_ffff;
          else if (acc < Q24_MIN) next_field[i] = 32'h8000_0000;
          else                    next_field[i] = acc[31:0];
        end
        // commit and track the peak over positive nodes only
        for (int i = 0; i <= last; i++) begin
          field_model[i] = next_field[i];
          if (field_model[i] > 0 && field_model[i][30:0] > peak_model)
            peak_model = field_model[i][30:0];
        end
        factor      = (model_cfg.decay_per_step > DECAY_ONE) ? DECAY_ONE
                                                            : model_cfg.decay_per_step;
        decay_prod  = decay_model * factor;
        decay_model = decay_prod[32:16];
      end
      KIND_READ: begin
        res.node_value = field_model[idx];
      end
      KIND_RESTART: begin
        clear_field_model();
      end
      default: ;
    endcase
    res.peak_value = peak_model;
    return res;
  endfunction

  // Set random bits above the register width now and then; the block drops them
  function automatic logic [31:0] pad_upper_bits(logic [31:0] value, int width);
    logic [31:0] junk;
    junk = $urandom();
    if (width < 32 && $urandom_range(0, 3) == 0) return value | (junk << width);
    return value;
  endfunction

  // APB write: setup cycle, access cycle, then drop select
  task automatic write_reg(reg_idx_e idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LAST_NODE:    model_cfg.last_node        = value[6:0];
      REG_DIFF_RATIO:   model_cfg.diffusion_ratio  = value[15:0];
      REG_SRC_INCR:     model_cfg.source_increment = value[30:0];
      REG_SRC_FIRST:    model_cfg.source_first     = value[6:0];
      REG_SRC_LAST:     model_cfg.source_last      = value[6:0];
      REG_DECAY_FACTOR: model_cfg.decay_per_step   = value[16:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_all_regs(logic [31:0] last_node, logic [31:0] ratio,
                                logic [31:0] incr, logic [31:0] first,
                                logic [31:0] last, logic [31:0] decay);
    write_reg(REG_LAST_NODE, last_node);
    write_reg(REG_DIFF_RATIO, ratio);
    write_reg(REG_SRC_INCR, incr);
    write_reg(REG_SRC_FIRST, first);
    write_reg(REG_SRC_LAST, last);
    write_reg(REG_DECAY_FACTOR, decay);
  endtask

  // Send one item; valid stays high so a back-to-back item needs no extra edge
  task automatic send_item(kind_e kind, logic [6:0] idx);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    repeat (gap) begin
      @(negedge clk);
      item_bus.valid <= 1'b0;
    end
    @(negedge clk);
    item_bus.valid      <= 1'b1;
    item_bus.kind       <= kind;
    item_bus.node_index <= idx;
    do @(posedge clk); while (!(item_bus.valid && item_bus.ready));
    node_results_due.push_back(apply_to_field_model(kind, idx));
  endtask

  // Drop valid and hold until every expected result has arrived
  task automatic wait_block_idle();
    @(negedge clk);
    item_bus.valid <= 1'b0;
    while (node_results_due.size() != 0) @(posedge clk);
  endtask

  // Default registers: source heating, diffusion into neighbours, reads past last node
  task automatic test_reset_state();
    idle_on = 1'b1;
    send_item(KIND_READ, 7'd0);
    send_item(KIND_NONE, 7'd127);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_READ, 7'd45);
    send_item(KIND_READ, 7'd55);
    send_item(KIND_READ, 7'd44);
    send_item(KIND_READ, 7'd100);
    send_item(KIND_READ, 7'd101);
    send_item(KIND_STEP, 7'd127);
    send_item(KIND_READ, 7'd44);
    send_item(KIND_RESTART, 7'd0);
    send_item(KIND_READ, 7'd45);
  endtask

  // Register extremes: saturation, negative center weight, decay to zero, empty source
  task automatic test_config_extremes();
    wait_block_idle();
    write_all_regs(32'd2, 32'd65535, 32'hffff_ffff, 32'd0, 32'd127, 32'h0001_ffff);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_READ, 7'd1);
    send_item(KIND_READ, 7'd2);
    send_item(KIND_READ, 7'd3);
    wait_block_idle();
    write_reg(REG_DECAY_FACTOR, 32'd0);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_READ, 7'd1);
    send_item(KIND_READ, 7'd0);
    wait_block_idle();
    write_all_regs(32'd127, 32'd0, 32'd0, 32'd10, 32'd5, {15'd0, DECAY_ONE});
    send_item(KIND_STEP, 7'd0);
    send_item(KIND_READ, 7'd127);
    send_item(KIND_READ, 7'd1);
    send_item(KIND_RESTART, 7'd0);
  endtask

  // Random register settings per phase, each followed by a batch of random items
  task automatic test_random_phases();
    int          sent;
    int          batch;
    int          pick;
    int          span;
    logic [31:0] last_node, ratio, incr, first, last, decay;
    kind_e       kind;
    logic [6:0]  idx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_block_idle();
      pick = $urandom_range(0, 9);
      if (pick == 0)      last_node = 127;
      else if (pick == 1) last_node = $urandom_range(16, 127);
      else                last_node = $urandom_range(2, 15);
      pick = $urandom_range(0, 9);
      if (pick == 0)      ratio = 0;
      else if (pick == 1) ratio = 65535;
      else if (pick < 7)  ratio = $urandom_range(0, 32768);
      else                ratio = $urandom_range(0, 65535);
      incr = ($urandom_range(0, 7) == 0) ? 32'd0 : ($urandom() >> $urandom_range(1, 31));
      span = (last_node + 2 > 127) ? 127 : last_node + 2;
      if ($urandom_range(0, 4) == 0) begin
        first = $urandom_range(0, 127);
        last  = $urandom_range(0, 127);
      end else begin
        first = $urandom_range(0, span);
        last  = $urandom_range(first, span);
        if ($urandom_range(0, 9) == 0) last = $urandom_range(0, first);
      end
      pick = $urandom_range(0, 9);
      if (pick == 0)      decay = DECAY_ONE;
      else if (pick == 1) decay = $urandom_range(65537, 131071);
      else if (pick == 2) decay = 0;
      else                decay = $urandom_range(50000, 65536);
      write_all_regs(pad_upper_bits(last_node, 7), pad_upper_bits(ratio, 16),
                     pad_upper_bits(incr, 31), pad_upper_bits(first, 7),
                     pad_upper_bits(last, 7), pad_upper_bits(decay, 17));
      idle_on = ($urandom_range(0, 3) != 0);
      batch   = $urandom_range(20, 80);
      repeat (batch) begin
        pick = $urandom_range(0, 99);
        if (pick < 45)      kind = KIND_STEP;
        else if (pick < 88) kind = KIND_READ;
        else if (pick < 95) kind = KIND_RESTART;
        else                kind = KIND_NONE;
        idx = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                          : 7'($urandom_range(0, span));
        send_item(kind, idx);
        if (kind != KIND_NONE) sent++;
      end
    end
  endtask

  // Result side: random stall before each transaction, then hold ready until taken
  initial begin : result_ready_driver
    int stall;
    result_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      repeat (stall) begin
        @(negedge clk);
        result_bus.ready <= 1'b0;
      end
      @(negedge clk);
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!(result_bus.valid && result_bus.ready));
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin : check_results
    node_result_t want;
    if (rst_n && result_bus.valid && result_bus.ready) begin
      if (node_results_due.size() == 0) begin
        $error("unexpected result transaction: node_value %0d peak_value %0d",
               result_bus.node_value, result_bus.peak_value);
        fail_count++;
      end else begin
        want = node_results_due.pop_front();
        if (result_bus.node_value !== want.node_value) begin
          $error("node_value mismatch: expected %0d, actual %0d",
                 want.node_value, result_bus.node_value);
          fail_count++;
        end
        if (result_bus.peak_value !== want.peak_value) begin
          $error("peak_value mismatch: expected %0d, actual %0d",
                 want.peak_value, result_bus.peak_value);
          fail_count++;
        end
      end
    end
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if ((item_bus.valid && item_bus.ready) || (result_bus.valid && result_bus.ready) ||
        (psel && penable && pwrite && pready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run_tests
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    item_bus.valid      = 1'b0;
    item_bus.kind       = KIND_STEP;
    item_bus.node_index = '0;
    model_cfg = '{last_node: 7'd100, diffusion_ratio: 16'd16384,
                  source_increment: 31'd4194304, source_first: 7'd45,
                  source_last: 7'd55, decay_per_step: DECAY_ONE};
    clear_field_model();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_state();
    test_config_extremes();
    test_random_phases();
    wait_block_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
